>>> rtl/tlc_pkg.sv
package tlc_pkg;

  localparam int WINDOW_LOG2 = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int WIN_SIZE    = 1 << WINDOW_LOG2;
  localparam int SUM_BITS    = SAMPLE_BITS + WINDOW_LOG2;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_CHANGE_THRESHOLD = 3'd0,
    CFG_INTEGRAL_LIMIT   = 3'd1,
    CFG_LEAK_AMOUNT      = 3'd2,
    CFG_TICKS_PER_SECOND = 3'd3,
    CFG_AUTO_OFF_SECONDS = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [14:0] change_threshold;
    logic [14:0] integral_limit;
    logic [14:0] leak_amount;
    logic [15:0] ticks_per_second;
    logic [14:0] auto_off_seconds;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_SETTLE = 3'b001,
    PH_IDLE   = 3'b010,
    PH_TOGGLE = 3'b100
  } phase_t;

  localparam logic [1:0] PHASE_CODE_SETTLE = 2'd0;
  localparam logic [1:0] PHASE_CODE_IDLE   = 2'd1;
  localparam logic [1:0] PHASE_CODE_TOGGLE = 2'd2;

  typedef struct packed {
    logic               touch;
    logic               refilling;
    logic [15:0]        baseline;
    logic signed [16:0] change;
    logic [15:0]        accumulated;
  } det_res_t;

  typedef struct packed {
    logic        lamp;
    logic [1:0]  phase;
    logic [14:0] seconds_left;
  } lamp_res_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_IDLE:   code = PHASE_CODE_IDLE;
      PH_TOGGLE: code = PHASE_CODE_TOGGLE;
      default:   code = PHASE_CODE_SETTLE;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/tlc_detect.sv
module tlc_detect (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  logic [tlc_pkg::SAMPLE_BITS-1:0]    sample,
  input  tlc_pkg::cfg_t                      cfg,
  input  logic                               restart,
  output tlc_pkg::det_res_t                  res
);
  import tlc_pkg::*;

  logic [SAMPLE_BITS-1:0]   store_r [WIN_SIZE];
  logic [SUM_BITS-1:0]      sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0]   avg_r, avg_nxt;
  logic [15:0]              integ_r, integ_nxt;
  logic [WINDOW_LOG2-1:0]   slot_r, slot_nxt;
  logic [WINDOW_LOG2:0]     fill_cnt_r, fill_cnt_nxt, fill_inc;
  logic                     refill_r, refill_nxt;

  logic [SAMPLE_BITS-1:0]   oldest;
  logic signed [16:0]       chg;
  logic                     over;
  logic [16:0]              integ_add;
  logic [15:0]              integ_mid;
  logic                     touch;
  logic                     wr_en;
  logic [WINDOW_LOG2-1:0]   wr_idx;

  always_comb begin
    oldest    = store_r[slot_r];
    chg       = $signed({1'b0, 16'(avg_r)}) - $signed({1'b0, 16'(sample)});
    over      = !chg[16] && (chg[15:0] > {1'b0, cfg.change_threshold});
    integ_add = {1'b0, integ_r} + {2'b0, cfg.change_threshold};
    fill_inc  = fill_cnt_r + 1'b1;

    sum_nxt      = sum_r;
    avg_nxt      = avg_r;
    integ_nxt    = integ_r;
    slot_nxt     = slot_r;
    fill_cnt_nxt = fill_cnt_r;
    refill_nxt   = refill_r;
    integ_mid    = integ_r;
    touch        = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = slot_r;

    if (refill_r) begin
      wr_en   = 1'b1;
      wr_idx  = fill_cnt_r[WINDOW_LOG2-1:0];
      sum_nxt = sum_r + SUM_BITS'(sample);
      if (fill_inc == (WINDOW_LOG2+1)'(WIN_SIZE)) begin
        refill_nxt   = 1'b0;
        fill_cnt_nxt = '0;
        slot_nxt     = '0;
        avg_nxt      = sum_nxt[SUM_BITS-1:WINDOW_LOG2];
      end else begin
        fill_cnt_nxt = fill_inc;
      end
    end else begin
      if (over) begin
        // large drop: treat as touch energy, keep it out of the baseline
        integ_mid = integ_add[16] ? 16'hFFFF : integ_add[15:0];
      end else begin
        wr_en    = 1'b1;
        sum_nxt  = sum_r - SUM_BITS'(oldest) + SUM_BITS'(sample);
        slot_nxt = slot_r + 1'b1;
        avg_nxt  = sum_nxt[SUM_BITS-1:WINDOW_LOG2];
      end
      touch = integ_mid > {1'b0, cfg.integral_limit};
      if (touch) begin
        integ_nxt = '0;
      end else if (integ_mid > {1'b0, cfg.leak_amount}) begin
        integ_nxt = integ_mid - {1'b0, cfg.leak_amount};
      end else begin
        integ_nxt = '0;
      end
    end

    if (restart) begin
      refill_nxt   = 1'b1;
      fill_cnt_nxt = '0;
      sum_nxt      = '0;
      integ_nxt    = '0;
    end

    res.touch       = touch;
    res.refilling   = refill_r;
    res.baseline    = 16'(avg_nxt);
    res.change      = refill_r ? 17'sd0 : chg;
    res.accumulated = integ_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      avg_r      <= '0;
      integ_r    <= '0;
      slot_r     <= '0;
      fill_cnt_r <= '0;
      refill_r   <= 1'b1;
    end else if (step) begin
      sum_r      <= sum_nxt;
      avg_r      <= avg_nxt;
      integ_r    <= integ_nxt;
      slot_r     <= slot_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      refill_r   <= refill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      store_r[wr_idx] <= sample;
    end
  end

endmodule

>>> rtl/tlc_lamp.sv
module tlc_lamp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                active,
  input  logic                touch,
  input  tlc_pkg::cfg_t       cfg,
  output logic                restart,
  output tlc_pkg::lamp_res_t  res
);
  import tlc_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        lamp_r, lamp_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [14:0] timer_r, timer_nxt;

  logic [15:0] tick_inc;
  logic        tick_over;

  always_comb begin
    tick_inc  = tick_r + 1'b1;
    tick_over = tick_inc > cfg.ticks_per_second;

    phase_nxt = phase_r;
    lamp_nxt  = lamp_r;
    tick_nxt  = tick_r;
    timer_nxt = timer_r;
    restart   = 1'b0;

    if (active) begin
      case (phase_r)
        PH_IDLE: begin
          if (lamp_r) begin
            if (timer_r != '0) begin
              if (tick_over) begin
                tick_nxt  = tick_inc - cfg.ticks_per_second;
                timer_nxt = timer_r - 1'b1;
              end else begin
                tick_nxt = tick_inc;
              end
            end else begin
              lamp_nxt = 1'b0;
            end
          end else begin
            timer_nxt = '0;
          end
          if (touch) begin
            phase_nxt = PH_TOGGLE;
          end
        end
        PH_TOGGLE: begin
          lamp_nxt  = !lamp_r;
          timer_nxt = lamp_r ? 15'd0 : cfg.auto_off_seconds;
          phase_nxt = PH_SETTLE;
          tick_nxt  = '0;
        end
        default: begin
          phase_nxt = PH_SETTLE;
          if (tick_over) begin
            tick_nxt  = tick_inc - cfg.ticks_per_second;
            phase_nxt = PH_IDLE;
            restart   = step;
          end else begin
            tick_nxt = tick_inc;
          end
        end
      endcase
    end

    res.lamp         = lamp_nxt;
    res.phase        = phase_code(phase_nxt);
    res.seconds_left = timer_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SETTLE;
      lamp_r  <= 1'b0;
      tick_r  <= '0;
      timer_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      lamp_r  <= lamp_nxt;
      tick_r  <= tick_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule

>>> rtl/touch_toggle_lamp_controller_unit.sv
// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------------
// input     | in_valid / in_ready    | in_sample
// result    | out_valid / out_ready  | out_touch, out_lamp, out_phase,
//           |                        | out_seconds_left, out_refilling,
//           |                        | out_baseline, out_change, out_accumulated
// config    | cfg_we                 | cfg_addr, cfg_wdata
//
// One request per cycle unless the result stalls; input register, then result register.
// The rate is set by the per-sample state update: window sum, integrator and lamp timer.
// Reset is synchronous, active low; the first 16 samples after reset refill the window.
// A stalled result holds the result register; one more request waits in the input register.
module touch_toggle_lamp_controller_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [15:0]                        in_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_touch,
  output logic                               out_lamp,
  output logic [1:0]                         out_phase,
  output logic [14:0]                        out_seconds_left,
  output logic                               out_refilling,
  output logic [15:0]                        out_baseline,
  output logic signed [16:0]                 out_change,
  output logic [15:0]                        out_accumulated,
  input  logic                               cfg_we,
  input  logic [tlc_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [tlc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import tlc_pkg::*;

  cfg_t                   cfg_r;
  logic                   in_v_r;
  logic [SAMPLE_BITS-1:0] in_sample_r;
  logic                   out_v_r;
  logic                   step;
  logic                   restart;
  det_res_t               det_res;
  lamp_res_t              lamp_res;

  assign step     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.change_threshold <= 15'd100;
      cfg_r.integral_limit   <= 15'd1000;
      cfg_r.leak_amount      <= 15'd10;
      cfg_r.ticks_per_second <= 16'd1000;
      cfg_r.auto_off_seconds <= 15'd3600;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CHANGE_THRESHOLD: cfg_r.change_threshold <= cfg_wdata[14:0];
        CFG_INTEGRAL_LIMIT:   cfg_r.integral_limit   <= cfg_wdata[14:0];
        CFG_LEAK_AMOUNT:      cfg_r.leak_amount      <= cfg_wdata[14:0];
        CFG_TICKS_PER_SECOND: cfg_r.ticks_per_second <= cfg_wdata;
        CFG_AUTO_OFF_SECONDS: cfg_r.auto_off_seconds <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_sample_r <= in_sample[SAMPLE_BITS-1:0];
    end
  end

  tlc_detect u_detect (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .sample  (in_sample_r),
    .cfg     (cfg_r),
    .restart (restart),
    .res     (det_res)
  );

  tlc_lamp u_lamp (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .active  (!det_res.refilling),
    .touch   (det_res.touch),
    .cfg     (cfg_r),
    .restart (restart),
    .res     (lamp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_touch        <= det_res.touch;
      out_refilling    <= det_res.refilling;
      out_baseline     <= det_res.baseline;
      out_change       <= det_res.change;
      out_accumulated  <= det_res.accumulated;
      out_lamp         <= lamp_res.lamp;
      out_phase        <= lamp_res.phase;
      out_seconds_left <= lamp_res.seconds_left;
    end
  end

  assign out_valid = out_v_r;

  // refill samples carry no detection
  a_refill_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_refilling |-> !out_touch && out_change == 17'sd0)
    else $error("refill result carries touch or change");

  // a dark lamp never has time left on the auto-off timer
  a_dark_no_timer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_lamp |-> out_seconds_left == 15'd0)
    else $error("lamp off with auto-off time left");

  // input side only backs up when the result register is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

endmodule
